// ===== rtl/core/photon256_permutation_macros.svh =====
// Assertion macros shared by the PHOTON-256 permutation RTL.
`ifndef PHOTON256_PERMUTATION_MACROS_SVH
`define PHOTON256_PERMUTATION_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PHOTON_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PHOTON_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/photon_pkg.sv =====
// Types, constants and GF(2^4) helpers for the PHOTON-256 permutation.
package photon_pkg;

    // Width of the round index into the constant table (12 rows)
    localparam int RC_W      = 4;
    localparam int RC_ROWS   = 12;
    localparam int WORD_W    = 64;
    localparam int STATE_W   = 256;
    localparam logic [1:0] LAST_IDX = 2'd3;

    // Input and output transactions
    typedef struct packed {
        logic [63:0] state_word;
        logic [1:0]  word_index;
    } t_in;

    typedef struct packed {
        logic [63:0] result_word;
        logic [1:0]  result_index;
        logic        last_word;
    } t_out;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_OUT
    } t_state;

    // Sequencer to datapath control
    typedef struct packed {
        logic            in_ready;
        logic            start;
        logic            round_en;
        logic            out_valid;
        logic            out_shift;
        logic [1:0]      out_idx;
        logic            last;
        logic [RC_W-1:0] rnd;
    } t_ctrl;

    // 8x8 matrix of GF(2^4) elements, [row][column]
    typedef logic [7:0][7:0][3:0] t_mds;

    // PRESENT S-box, entry x at nibble x
    localparam logic [63:0] SBOX = 64'h21748FE3DA09B65C;

    // Last row of the serial matrix, coefficient k at nibble k
    localparam logic [31:0] SERIAL = 32'h6582B242;

    // Multiply in GF(2^4) modulo x^4+x+1
    function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] r;
        logic [4:0] t;
        r = '0;
        t = {1'b0, a};
        for (int k = 0; k < 4; k++) begin
            if (b[k]) begin
                r = r ^ t[3:0];
            end
            t = {t[3:0], 1'b0};
            if (t[4]) begin
                t = t ^ 5'h13;
            end
        end
        return r;
    endfunction

    // Full mixing matrix: eight applications of the serial step, per unit vector
    function automatic t_mds mds_matrix();
        t_mds            m;
        logic [7:0][3:0] t;
        logic [3:0]      acc;
        m = '0;
        for (int j = 0; j < 8; j++) begin
            t    = '0;
            t[j] = 4'h1;
            for (int n = 0; n < 8; n++) begin
                acc = '0;
                for (int k = 0; k < 8; k++) begin
                    acc = acc ^ gf_mul(SERIAL[4*k +: 4], t[k]);
                end
                t = {acc, t[7:1]};
            end
            for (int i = 0; i < 8; i++) begin
                m[i][j] = t[i];
            end
        end
        return m;
    endfunction

    localparam t_mds MDS = mds_matrix();

    // Round constants, row i at nibble i
    function automatic logic [31:0] rc_row(input logic [RC_W-1:0] r);
        logic [31:0] v;
        case (r)
            4'd0:    v = 32'h9DFE6201;
            4'd1:    v = 32'hBFDC4023;
            4'd2:    v = 32'hFB980467;
            4'd3:    v = 32'h62019DFE;
            4'd4:    v = 32'h5132AECD;
            4'd5:    v = 32'h3754C8AB;
            4'd6:    v = 32'hEA891576;
            4'd7:    v = 32'h4023BFDC;
            4'd8:    v = 32'h1576EA89;
            4'd9:    v = 32'hAECD5132;
            4'd10:   v = 32'hD9BA2645;
            4'd11:   v = 32'h2645D9BA;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/photon_round.sv =====
// One PHOTON-256 round: constants, S-box layer, row rotation, column mixing.
module photon_round
    import photon_pkg::*;
(
    input  logic [STATE_W-1:0] i_state,
    input  logic [RC_W-1:0]    i_rnd,
    output logic [STATE_W-1:0] o_state
);

    logic [7:0][7:0][3:0] c_in;
    logic [7:0][7:0][3:0] c_sub;
    logic [7:0][7:0][3:0] c_rot;
    logic [7:0][7:0][3:0] c_mix;
    logic [31:0]          rc;

    // Cell (row i, column j) sits at bit 32i+4j
    assign c_in = i_state;
    assign rc   = rc_row(i_rnd);

    // Add constants to column 0, then S-box every cell
    always_comb begin
        logic [3:0] v;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                v = c_in[i][j];
                if (j == 0) begin
                    v = v ^ rc[4*i +: 4];
                end
                c_sub[i][j] = SBOX[4*v +: 4];
            end
        end
    end

    // Rotate row i left by i cells
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                c_rot[i][j] = c_sub[i][(j + i) % 8];
            end
        end
    end

    // Mix each column with the full MDS matrix (constant multipliers)
    always_comb begin
        logic [3:0] acc;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                acc = '0;
                for (int k = 0; k < 8; k++) begin
                    acc = acc ^ gf_mul(MDS[i][k], c_rot[k][j]);
                end
                c_mix[i][j] = acc;
            end
        end
    end

    assign o_state = c_mix;

endmodule

// ===== rtl/core/photon_ctrl.sv =====
// Sequencer for the PHOTON-256 permutation: load, round loop and word output.
`include "photon256_permutation_macros.svh"

module photon_ctrl
    import photon_pkg::*;
#(
    parameter int ROUNDS = 12
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_last,
    input  logic  i_out_ready,
    output t_ctrl o_ctrl
);

    // Only as many rounds as there are constant rows
    localparam int RND_EFF = (ROUNDS < RC_ROWS) ? ROUNDS : RC_ROWS;
    localparam logic [RC_W-1:0] RND_LAST = RC_W'(RND_EFF - 1);

    t_state          r_state, n_state;
    logic [RC_W-1:0] r_round, n_round;
    logic [1:0]      r_outcnt, n_outcnt;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_in_valid && i_in_last) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_round == RND_LAST) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_ready && r_outcnt == LAST_IDX) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Outputs and counter updates
    always_comb begin
        o_ctrl   = '0;
        n_round  = r_round;
        n_outcnt = r_outcnt;
        o_ctrl.rnd     = r_round;
        o_ctrl.out_idx = r_outcnt;
        o_ctrl.last    = (r_outcnt == LAST_IDX);
        unique case (r_state)
            ST_LOAD: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.start    = i_in_valid && i_in_last;
                n_round         = '0;
                n_outcnt        = '0;
            end
            ST_RUN: begin
                o_ctrl.round_en = 1'b1;
                n_round         = r_round + 1'b1;
            end
            ST_OUT: begin
                o_ctrl.out_valid = 1'b1;
                o_ctrl.out_shift = i_out_ready;
                if (i_out_ready) begin
                    n_outcnt = r_outcnt + 1'b1;
                end
            end
            default: begin
                n_round  = '0;
                n_outcnt = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_round  <= '0;
            r_outcnt <= '0;
        end else begin
            r_state  <= n_state;
            r_round  <= n_round;
            r_outcnt <= n_outcnt;
        end
    end

    // Checks
    `PHOTON_ASSERT_SAME(a_ready_excl, o_ctrl.in_ready, !o_ctrl.out_valid && !o_ctrl.round_en, "ready while busy")
    `PHOTON_ASSERT_NEXT(a_start_run, o_ctrl.start, r_state == ST_RUN && r_round == '0, "start did not enter round loop")
    `PHOTON_ASSERT_SAME(a_round_range, r_state == ST_RUN, r_round <= RND_LAST, "round counter out of range")
    `PHOTON_ASSERT_NEXT(a_out_done, o_ctrl.out_valid && i_out_ready && o_ctrl.last, o_ctrl.in_ready, "no return to load after last word")

endmodule

// ===== rtl/core/photon256_permutation.sv =====
// PHOTON-256 permutation top level: word buffer, state register, round unit and sequencer.
//
// Words with index 0 to 2 are stored in the buffer. A word with index 3 is
// stored and starts the permutation of the four buffered words; the block then
// runs one round per cycle through a single round unit, ROUNDS rounds (12 by
// default, at most 12), and presents the four permuted words in order, index 0
// first, last_word set on index 3, one per cycle when the sink is ready. From
// the start word until the last result transaction the input is not ready.
// The buffer keeps the loaded words, so a new word 3 alone re-runs the
// permutation on the earlier words 0 to 2.
module photon256_permutation
    import photon_pkg::*;
#(
    parameter int ROUNDS = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    t_ctrl                         ctrl;
    logic [3:0][WORD_W-1:0]        r_buf;
    logic [STATE_W-1:0]            r_state;
    logic [STATE_W-1:0]            round_out;
    logic                          in_xact;

    photon_ctrl #(
        .ROUNDS (ROUNDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in.word_index == LAST_IDX),
        .i_out_ready (i_out_ready),
        .o_ctrl      (ctrl)
    );

    photon_round u_round (
        .i_state (r_state),
        .i_rnd   (ctrl.rnd),
        .o_state (round_out)
    );

    assign in_xact = i_in_valid && ctrl.in_ready;

    // Input word buffer
    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_buf[i_in.word_index] <= i_in.state_word;
        end
    end

    // Working state: load, round update, then shift out one word per transaction
    always_ff @(posedge i_clk) begin
        if (ctrl.start) begin
            r_state <= {i_in.state_word, r_buf[2], r_buf[1], r_buf[0]};
        end else if (ctrl.round_en) begin
            r_state <= round_out;
        end else if (ctrl.out_shift) begin
            r_state <= {{WORD_W{1'b0}}, r_state[STATE_W-1:WORD_W]};
        end
    end

    // Ports
    assign o_in_ready         = ctrl.in_ready;
    assign o_out_valid        = ctrl.out_valid;
    assign o_out.result_word  = r_state[WORD_W-1:0];
    assign o_out.result_index = ctrl.out_idx;
    assign o_out.last_word    = ctrl.last;

endmodule

// ===== test/tb_photon256_permutation.sv =====
// Self-checking testbench for the PHOTON-256 permutation block with a built-in predictor.
module tb_photon256_permutation
    import photon_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PERM_ROUNDS  = 12;
    localparam int IDLE_PCT     = 27;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 390;
    localparam int HOLD_AFTER   = 80;   // result words seen before the long sink stall
    localparam int HOLD_CYCLES  = 64;

    // State as an 8x8 grid of nibbles, [row][column]; cell (i,j) sits at bit 32*i + 4*j
    typedef logic [7:0][7:0][3:0] cell_grid_t;

    localparam logic [3:0] PRESENT_SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    localparam logic [3:0] ROUND_CONST [12][8] = '{
        '{4'h1, 4'h0, 4'h2, 4'h6, 4'hE, 4'hF, 4'hD, 4'h9},
        '{4'h3, 4'h2, 4'h0, 4'h4, 4'hC, 4'hD, 4'hF, 4'hB},
        '{4'h7, 4'h6, 4'h4, 4'h0, 4'h8, 4'h9, 4'hB, 4'hF},
        '{4'hE, 4'hF, 4'hD, 4'h9, 4'h1, 4'h0, 4'h2, 4'h6},
        '{4'hD, 4'hC, 4'hE, 4'hA, 4'h2, 4'h3, 4'h1, 4'h5},
        '{4'hB, 4'hA, 4'h8, 4'hC, 4'h4, 4'h5, 4'h7, 4'h3},
        '{4'h6, 4'h7, 4'h5, 4'h1, 4'h9, 4'h8, 4'hA, 4'hE},
        '{4'hC, 4'hD, 4'hF, 4'hB, 4'h3, 4'h2, 4'h0, 4'h4},
        '{4'h9, 4'h8, 4'hA, 4'hE, 4'h6, 4'h7, 4'h5, 4'h1},
        '{4'h2, 4'h3, 4'h1, 4'h5, 4'hD, 4'hC, 4'hE, 4'hA},
        '{4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'hB, 4'h9, 4'hD},
        '{4'hA, 4'hB, 4'h9, 4'hD, 4'h5, 4'h4, 4'h6, 4'h2}
    };

    // Bottom row of the serial mixing step
    localparam logic [3:0] MIX_ROW [8] = '{4'h2, 4'h4, 4'h2, 4'hB, 4'h2, 4'h8, 4'h5, 4'h6};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    t_in         pending_items[$];
    t_out        expected_words[$];
    logic [63:0] load_buffer [4];

    int cycle_count     = 0;
    int words_loaded    = 0;
    int results_checked = 0;
    int perms_started   = 0;
    int mismatch_count  = 0;
    logic hold_off  = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    photon256_permutation uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // GF(2^4) product modulo x^4+x+1
    function automatic logic [3:0] gf16_times(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] acc;
        logic [3:0] x;
        acc = '0;
        x   = a;
        for (int k = 0; k < 4; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
        end
        return acc;
    endfunction

    // Full PHOTON-256 permutation of a 256-bit state
    function automatic logic [255:0] photon256_permute(input logic [255:0] s);
        cell_grid_t g;
        logic [3:0] line [8];
        logic [3:0] acc;
        g = s;
        for (int r = 0; r < PERM_ROUNDS; r++) begin
            for (int i = 0; i < 8; i++) begin
                g[i][0] = g[i][0] ^ ROUND_CONST[r][i];
            end
            for (int i = 0; i < 8; i++) begin
                for (int j = 0; j < 8; j++) begin
                    g[i][j] = PRESENT_SBOX[g[i][j]];
                end
            end
            // row i rotates left by i cells
            for (int i = 1; i < 8; i++) begin
                for (int j = 0; j < 8; j++) begin
                    line[j] = g[i][j];
                end
                for (int j = 0; j < 8; j++) begin
                    g[i][j] = line[(j + i) % 8];
                end
            end
            // column mixing: eight serial steps per column
            for (int j = 0; j < 8; j++) begin
                for (int i = 0; i < 8; i++) begin
                    line[i] = g[i][j];
                end
                for (int n = 0; n < 8; n++) begin
                    acc = '0;
                    for (int k = 0; k < 8; k++) begin
                        acc = acc ^ gf16_times(MIX_ROW[k], line[k]);
                    end
                    for (int k = 0; k < 7; k++) begin
                        line[k] = line[k + 1];
                    end
                    line[7] = acc;
                end
                for (int i = 0; i < 8; i++) begin
                    g[i][j] = line[i];
                end
            end
        end
        return g;
    endfunction

    // Store an accepted word; the start word queues the four permuted words
    function automatic void record_word(input t_in item);
        logic [255:0] permuted;
        t_out         word_out;
        load_buffer[item.word_index] = item.state_word;
        if (item.word_index == LAST_IDX) begin
            perms_started++;
            permuted = photon256_permute({load_buffer[3], load_buffer[2],
                                          load_buffer[1], load_buffer[0]});
            for (int k = 0; k < 4; k++) begin
                word_out.result_word  = permuted[64*k +: 64];
                word_out.result_index = 2'(k);
                word_out.last_word    = (k == 3);
                expected_words.push_back(word_out);
            end
        end
    endfunction

    function automatic void report_mismatch(input string what, input logic [63:0] want,
                                            input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
        end
    endfunction

    function automatic void check_result(input t_out got);
        t_out want;
        if (expected_words.size() == 0) begin
            report_mismatch("result word with none outstanding", '0, got.result_word);
        end else begin
            want = expected_words.pop_front();
            if (got.result_word !== want.result_word) begin
                report_mismatch("result_word", want.result_word, got.result_word);
            end
            if (got.result_index !== want.result_index) begin
                report_mismatch("result_index", 64'(want.result_index), 64'(got.result_index));
            end
            if (got.last_word !== want.last_word) begin
                report_mismatch("last_word", 64'(want.last_word), 64'(got.last_word));
            end
        end
    endfunction

    function automatic void push_item(input logic [63:0] word, input logic [1:0] index);
        t_in item;
        item.state_word = word;
        item.word_index = index;
        pending_items.push_back(item);
    endfunction

    // Random word biased towards the extremes and single-bit patterns
    function automatic logic [63:0] random_word();
        logic [63:0] w;
        case ($urandom_range(7))
            0:       w = '0;
            1:       w = '1;
            2:       w = 64'd1 << $urandom_range(63);
            3:       w = ~(64'd1 << $urandom_range(63));
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // Sender: offers queued items, idling at random outside its quiet stretch
    always @(posedge i_clk) begin : drive_proc
        logic load_next;
        logic quiet;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            load_next = !i_in_valid;
            quiet     = (words_loaded >= 150 && words_loaded < 260);
            if (i_in_valid && o_in_ready) begin
                record_word(i_in);
                words_loaded <= words_loaded + 1;
                load_next = 1'b1;
            end
            if (load_next) begin
                if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    i_in       <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // One long sink stall so the block backs up and holds off its input
    always @(posedge i_clk) begin
        if (!hold_done && !hold_off && results_checked >= HOLD_AFTER) begin
            hold_off  <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_off) begin
            if (hold_left == 1) begin
                hold_off  <= 1'b0;
                hold_done <= 1'b1;
            end
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks each result transaction and drives ready
    always @(posedge i_clk) begin : sink_proc
        logic quiet;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            quiet = (results_checked >= 200 && results_checked < 360);
            if (o_out_valid && i_out_ready) begin
                check_result(o_out);
                results_checked <= results_checked + 1;
            end
            i_out_ready <= !hold_off && (quiet || $urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run stopped by the cycle limit (%0d cycles)", CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int order [3];
        int pick;
        int tmp;

        // all-zero and all-one states
        for (int k = 0; k < 4; k++) begin
            push_item('0, 2'(k));
        end
        for (int k = 0; k < 4; k++) begin
            push_item('1, 2'(k));
        end
        // start word alone re-runs on the buffered words
        push_item('0, LAST_IDX);
        // out-of-order loading
        push_item(64'h5555_5555_5555_5555, 2'd2);
        push_item(64'hAAAA_AAAA_AAAA_AAAA, 2'd0);
        push_item(64'h0123_4567_89AB_CDEF, 2'd1);
        push_item(64'hFEDC_BA98_7654_3210, LAST_IDX);
        // a word overwritten before the start
        push_item(64'hDEAD_BEEF_0BAD_F00D, 2'd1);
        push_item(64'h8000_0000_0000_0001, 2'd1);
        push_item(64'h7FFF_FFFF_FFFF_FFFE, LAST_IDX);
        // single bits at the ends of the state
        push_item(64'd1, 2'd0);
        push_item(64'h8000_0000_0000_0000, LAST_IDX);

        // random part: mostly complete loads, some partial updates, some loose words
        while (pending_items.size() < 18 + RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                order = '{0, 1, 2};
                for (int k = 2; k > 0; k--) begin
                    tmp = $urandom_range(k);
                    {order[k], order[tmp]} = {order[tmp], order[k]};
                end
                for (int k = 0; k < 3; k++) begin
                    push_item(random_word(), 2'(order[k]));
                end
                push_item(random_word(), LAST_IDX);
            end else if (pick < 85) begin
                for (int k = 0; k < 3; k++) begin
                    if ($urandom_range(1) == 1) begin
                        push_item(random_word(), 2'(k));
                    end
                end
                push_item(random_word(), LAST_IDX);
            end else begin
                push_item(random_word(), 2'($urandom_range(3)));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words loaded, %0d permutations started, %0d result words checked",
                 words_loaded, perms_started, results_checked);
        $display("sink stalled for %0d cycles once; %0d field mismatches",
                 HOLD_CYCLES, mismatch_count);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
